// ===== rtl/core/awm_pkg.sv =====
// awm_pkg: request codes, letter width and shared structs of the anagram window matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package awm_pkg;

	localparam int REQ_W    = 2;
	localparam int LETTER_W = 5;

	localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PATTERN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TEXT    = 2'd2;

	typedef struct packed {
		logic window_match;
		logic found_any;
		logic pattern_overflow;
	} awm_res_t;

	typedef struct packed {
		logic                clear_all;
		logic                clear_win;
		logic                pat_add;
		logic                txt_add;
		logic                txt_evict;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] old;
	} awm_cnt_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/awm_req_if.sv =====
// awm_req_if: request channel, valid/ready with req_type and letter
// depends on awm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface awm_req_if;
	logic                           valid;
	logic                           ready;
	logic [awm_pkg::REQ_W-1:0]      req_type;
	logic [awm_pkg::LETTER_W-1:0]   letter;

	modport source (output valid, output req_type, output letter, input ready);
	modport sink (input valid, input req_type, input letter, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/awm_res_if.sv =====
// awm_res_if: result channel, valid/ready with match and flag bits
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface awm_res_if;
	logic valid;
	logic ready;
	logic window_match;
	logic found_any;
	logic pattern_overflow;

	modport source (output valid, output window_match, output found_any,
		output pattern_overflow, input ready);
	modport sink (input valid, input window_match, input found_any,
		input pattern_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/anagram_window_matcher.sv =====
// anagram_window_matcher: the result of an item is registered in the output buffer as it is
// accepted; throughput 1 item per cycle while the skid entry is free, set by the update of the
// per-letter count cells and the shift of the window chain. The skid entry lets an
// item in while a result waits. Reset clears counts, length, flags and handshake
// state at once; the window chain holds no reset value and is only read once filled.
// depends on awm_pkg, awm_req_if, awm_res_if, awm_ring_cell, awm_count_cell, awm_out_buf
`timescale 1ns / 1ps
`default_nettype none

module anagram_window_matcher #(
	parameter int MAX_LEN  = 64,
	parameter int ALPHABET = 26
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	awm_req_if.sink    request,
	awm_res_if.source  result
);
	import awm_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);

	logic [LW-1:0]       plen_q;
	logic [LW-1:0]       seen_q;
	logic [LW-1:0]       entry_q;
	logic                found_q;
	logic                ovf_q;

	logic                acc;
	logic                letter_ok;
	logic                is_clr;
	logic                is_pat;
	logic                is_txt;
	logic                plen_zero;
	logic                plen_max;
	logic                full;
	logic                txt_store;
	logic                evict;
	logic                match;
	logic                can_push;
	logic [ALPHABET-1:0] eq_vec;
	logic [LETTER_W-1:0] ring_data [MAX_LEN];
	awm_cnt_ctl_t        ctl;
	awm_res_t            res_d;
	awm_res_t            res_q;

	assign acc       = request.valid && request.ready;
	assign letter_ok = (32'(request.letter) < ALPHABET);
	assign is_clr    = acc && (request.req_type == REQ_CLEAR);
	assign is_pat    = acc && (request.req_type == REQ_PATTERN) && letter_ok;
	assign is_txt    = acc && (request.req_type == REQ_TEXT) && letter_ok;
	assign plen_zero = (plen_q == '0);
	assign plen_max  = (plen_q == LW'(MAX_LEN));
	assign full      = (seen_q == plen_q);
	assign txt_store = is_txt && !plen_zero;
	assign evict     = txt_store && full;
	assign match     = is_txt && (plen_zero || (&eq_vec));

	always_comb begin
		ctl.clear_all = is_clr;
		ctl.clear_win = is_pat;
		ctl.pat_add   = is_pat && !plen_max;
		ctl.txt_add   = txt_store;
		ctl.txt_evict = evict;
		ctl.letter    = request.letter;
		ctl.old       = ring_data[MAX_LEN-1];
	end

	// window chain: letters enter at MAX_LEN - pattern length, the oldest sits at the end
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_ring
		awm_ring_cell #(
			.IDX (i),
			.LW  (LW)
		) u_cell (
			.clk        (clk),
			.shift      (txt_store),
			.entry      (entry_q),
			.new_letter (request.letter),
			.left       ((i == 0) ? request.letter : ring_data[(i == 0) ? 0 : i-1]),
			.data       (ring_data[i])
		);
	end

	for (genvar k = 0; k < ALPHABET; k++) begin : g_cnt
		awm_count_cell #(
			.IDX (k),
			.CW  (LW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.eq     (eq_vec[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			seen_q  <= '0;
			entry_q <= LW'(MAX_LEN);
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (is_clr) begin
			plen_q  <= '0;
			seen_q  <= '0;
			entry_q <= LW'(MAX_LEN);
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (is_pat) begin
			seen_q <= '0;
			if (plen_max) begin
				ovf_q <= 1'b1;
			end else begin
				plen_q  <= plen_q + LW'(1);
				entry_q <= entry_q - LW'(1);
			end
		end else if (is_txt) begin
			if (txt_store && !full) begin
				seen_q <= seen_q + LW'(1);
			end
			if (match) begin
				found_q <= 1'b1;
			end
		end
	end

	always_comb begin
		res_d.window_match     = match;
		res_d.found_any        = !is_clr && (found_q || match);
		res_d.pattern_overflow = !is_clr && (ovf_q || (is_pat && plen_max));
	end

	awm_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res_d),
		.can_push  (can_push),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_q)
	);

	assign request.ready           = can_push;
	assign result.window_match     = res_q.window_match;
	assign result.found_any        = res_q.found_any;
	assign result.pattern_overflow = res_q.pattern_overflow;

endmodule

`default_nettype wire

// ===== rtl/core/awm_ring_cell.sv =====
// awm_ring_cell: one stage of the text window shift chain
// depends on awm_pkg
`timescale 1ns / 1ps
`default_nettype none

module awm_ring_cell #(
	parameter int IDX = 0,
	parameter int LW  = 7
) (
	input  wire logic                         clk,
	input  wire logic                         shift,
	input  wire logic [LW-1:0]                entry,
	input  wire logic [awm_pkg::LETTER_W-1:0] new_letter,
	input  wire logic [awm_pkg::LETTER_W-1:0] left,
	output logic      [awm_pkg::LETTER_W-1:0] data
);
	import awm_pkg::*;

	logic [LETTER_W-1:0] data_q;

	// the entry cell takes the new letter, the others take their left neighbor
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= (entry == LW'(IDX)) ? new_letter : left;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/awm_count_cell.sv =====
// awm_count_cell: pattern and window count of one letter, with next-state compare
// depends on awm_pkg
`timescale 1ns / 1ps
`default_nettype none

module awm_count_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire awm_pkg::awm_cnt_ctl_t ctl,
	output logic                       eq
);
	import awm_pkg::*;

	logic [CW-1:0] pat_q;
	logic [CW-1:0] win_q;
	logic [CW-1:0] pat_d;
	logic [CW-1:0] win_d;
	logic          hit_new;
	logic          hit_old;
	logic          inc;
	logic          dec;

	assign hit_new = (32'(ctl.letter) == IDX);
	assign hit_old = (32'(ctl.old) == IDX);
	assign inc     = ctl.txt_add && hit_new;
	assign dec     = ctl.txt_evict && hit_old && (win_q != '0);

	always_comb begin
		if (ctl.clear_all) begin
			pat_d = '0;
		end else if (ctl.pat_add && hit_new) begin
			pat_d = pat_q + CW'(1);
		end else begin
			pat_d = pat_q;
		end
		if (ctl.clear_all || ctl.clear_win) begin
			win_d = '0;
		end else begin
			win_d = win_q + CW'(inc) - CW'(dec);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			win_q <= '0;
		end else begin
			pat_q <= pat_d;
			win_q <= win_d;
		end
	end

	assign eq = (pat_d == win_d);

endmodule

`default_nettype wire

// ===== rtl/core/awm_out_buf.sv =====
// awm_out_buf: output register with skid entry for result items
// depends on awm_pkg
`timescale 1ns / 1ps
`default_nettype none

module awm_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire awm_pkg::awm_res_t push_data,
	output logic                   can_push,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output awm_pkg::awm_res_t      out_data
);
	import awm_pkg::*;

	logic     main_v_q;
	logic     skid_v_q;
	awm_res_t main_q;
	awm_res_t skid_q;
	logic     pop;

	assign pop = main_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (!push) begin
				main_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (!main_v_q) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign can_push  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire
